FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl datapath module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/pipt_pkg.sv
// shared types and constants of the point in polygon test block
package pipt_pkg;

	localparam int CFG_W = 7;
	localparam int SLOT_W = 6;
	localparam logic [CFG_W-1:0] VCOUNT_RST = 7'd4;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CLOSE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic wr;
		logic clear;
		logic rd;
		logic first;
		logic close;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_hold;
	} sts_t;

endpackage

FILE: rtl/core/pipt_dp.sv
// datapath: vertex memory, edge pipeline, crossing accumulators and result register
`include "assert_macros.svh"

module pipt_dp #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS = 16,
	parameter int AW = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pipt_pkg::cmd_t                 cmd,
	input  logic [AW-1:0]                  rd_addr,
	input  logic [pipt_pkg::SLOT_W-1:0]    slot,
	input  logic signed [COORD_BITS-1:0]   coord_x,
	input  logic signed [COORD_BITS-1:0]   coord_y,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic                           inside_res,
	output logic                           on_edge,
	output pipt_pkg::sts_t                 sts
);

	localparam int W = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;

	logic [2*W-1:0] mem [MAX_VERTICES];

	// stage 1: read data and command flags
	logic [2*W-1:0] rdata_s1;
	logic rd_s1, first_s1, close_s1;

	logic signed [W-1:0] px_q, py_q;
	logic signed [W-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;

	logic signed [W-1:0] cur_x, cur_y, ax, ay, bx, by;
	logic edge_v, box, cand, up;
	logic signed [DW-1:0] ux, uy, vx, vy;

	// stage 2: differences and flags
	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic box_s2, cand_s2, up_s2, valid_s2;

	// stage 3: products
	logic signed [PW-1:0] p1_s3, p2_s3;
	logic box_s3, cand_s3, up_s3, valid_s3;

	logic signed [SW-1:0] diff;
	logic s_zero, s_pos, s_neg, hit, flip;

	logic on_edge_q, parity_q;
	logic out_valid_q, inside_q, on_edge_out_q;

	always_ff @(posedge clk) begin
		if (cmd.wr && (32'(slot) < MAX_VERTICES)) begin
			mem[AW'(slot)] <= {coord_x, coord_y};
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			first_s1 <= 1'b0;
			close_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			first_s1 <= cmd.rd && cmd.first;
			close_s1 <= cmd.close;
			valid_s2 <= edge_v;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		cur_x = rdata_s1[2*W-1:W];
		cur_y = rdata_s1[W-1:0];
		edge_v = (rd_s1 && !first_s1) || close_s1;
		ax = prev_x_q;
		ay = prev_y_q;
		bx = close_s1 ? first_x_q : cur_x;
		by = close_s1 ? first_y_q : cur_y;
		ux = DW'(bx) - DW'(ax);
		uy = DW'(by) - DW'(ay);
		vx = DW'(px_q) - DW'(ax);
		vy = DW'(py_q) - DW'(ay);
		box = ((ax <= px_q && px_q <= bx) || (bx <= px_q && px_q <= ax)) &&
			((ay <= py_q && py_q <= by) || (by <= py_q && py_q <= ay));
		cand = (ay != by) && ((ay >= py_q) != (by >= py_q));
		up = by > ay;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (rd_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (first_s1) begin
			first_x_q <= cur_x;
			first_y_q <= cur_y;
		end
		ux_s2 <= ux;
		uy_s2 <= uy;
		vx_s2 <= vx;
		vy_s2 <= vy;
		box_s2 <= box;
		cand_s2 <= cand;
		up_s2 <= up;
		p1_s3 <= PW'(ux_s2) * PW'(vy_s2);
		p2_s3 <= PW'(vx_s2) * PW'(uy_s2);
		box_s3 <= box_s2;
		cand_s3 <= cand_s2;
		up_s3 <= up_s2;
	end

	always_comb begin
		diff = SW'(p1_s3) - SW'(p2_s3);
		s_zero = (diff == '0);
		s_neg = diff[SW-1];
		s_pos = !s_neg && !s_zero;
		hit = box_s3 && s_zero;
		flip = cand_s3 && (up_s3 ? s_pos : s_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_edge_q <= 1'b0;
			parity_q <= 1'b0;
		end else if (cmd.clear) begin
			on_edge_q <= 1'b0;
			parity_q <= 1'b0;
		end else if (valid_s3) begin
			on_edge_q <= on_edge_q | hit;
			parity_q <= parity_q ^ flip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			inside_q <= on_edge_q | parity_q;
			on_edge_out_q <= on_edge_q;
		end
	end

	assign out_valid = out_valid_q;
	assign inside_res = inside_q;
	assign on_edge = on_edge_out_q;
	assign sts.busy = rd_s1 || close_s1 || valid_s2 || valid_s3;
	assign sts.out_hold = out_valid_q && out_stall;

	`ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_out, !(out_valid_q && out_stall))
	`ASSERT_IMP(a_clear_when_empty, clk, arst_n, cmd.clear, !sts.busy)
	`ASSERT_IMP(a_s3_follows_s2, clk, arst_n, valid_s3, $past(valid_s2))

endmodule

FILE: rtl/core/pipt_ctrl.sv
// controller: vertex count register and query sequencing state machine
module pipt_ctrl #(
	parameter int MAX_VERTICES = 64,
	parameter int AW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          opcode,
	input  logic                          cfg_we,
	input  logic [pipt_pkg::CFG_W-1:0]    cfg_wdata,
	input  pipt_pkg::sts_t                sts,
	output logic                          in_stall,
	output logic [AW-1:0]                 rd_addr,
	output pipt_pkg::cmd_t                cmd
);

	localparam int CW = pipt_pkg::CFG_W;

	pipt_pkg::state_t state_q, state_d;
	logic [CW-1:0] vcount_q, n_eff, cnt_q;
	logic last, is_query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= pipt_pkg::VCOUNT_RST;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// counts above the store depth act as the depth
	always_comb begin
		n_eff = (32'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : vcount_q;
		last = (cnt_q == n_eff - CW'(1));
		is_query = in_valid && (opcode == pipt_pkg::OP_QUERY);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pipt_pkg::ST_IDLE: begin
				if (is_query) begin
					state_d = (n_eff == '0) ? pipt_pkg::ST_DRAIN : pipt_pkg::ST_READ;
				end
			end
			pipt_pkg::ST_READ: begin
				if (last) begin
					state_d = pipt_pkg::ST_CLOSE;
				end
			end
			pipt_pkg::ST_CLOSE: begin
				state_d = pipt_pkg::ST_DRAIN;
			end
			pipt_pkg::ST_DRAIN: begin
				if (!sts.busy && !sts.out_hold) begin
					state_d = pipt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pipt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			pipt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.wr = in_valid && (opcode == pipt_pkg::OP_WRITE);
				cmd.clear = is_query;
			end
			pipt_pkg::ST_READ: begin
				cmd.rd = 1'b1;
				cmd.first = (cnt_q == '0);
			end
			pipt_pkg::ST_CLOSE: begin
				cmd.close = 1'b1;
			end
			pipt_pkg::ST_DRAIN: begin
				cmd.load_out = !sts.busy && !sts.out_hold;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pipt_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pipt_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == pipt_pkg::ST_READ) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign rd_addr = AW'(cnt_q);

endmodule

FILE: rtl/core/point_in_polygon_test_top.sv
// Point in polygon test, top level.
// Input channel: in_valid / in_stall with opcode, slot, coord_x, coord_y.
// A write item (opcode 0) stores one vertex at slot and gives no result;
// slots at or beyond the store depth are dropped.
// A query item (opcode 1) walks every edge of the polygon, vertex_count edges closed
// back to vertex zero, and gives one item on out_valid / out_stall with inside_res
// and on_edge. The single vertex memory read port steps once per vertex, then the
// closing edge is issued; the result is loaded once the pipeline has drained and the
// output register is free (a count of zero reads no vertex; counts above the store
// depth act as the depth). The next item is taken in the cycle after the result is
// loaded; in_stall is high until then. The user must write the vertex count through
// cfg_we / cfg_wdata only while the block is idle; the block does not enforce this.
// The result sits in an output register and holds while out_stall is high; items are
// still taken, but a later query that finishes meanwhile waits for the register
// with in_stall high.
// Reset clears the control state and sets the vertex count to four; vertex
// storage is not cleared and must be written before it is queried.
module point_in_polygon_test_top #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pipt_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [pipt_pkg::SLOT_W-1:0]   slot,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res,
	output logic                          on_edge
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	pipt_pkg::cmd_t cmd;
	pipt_pkg::sts_t sts;
	logic [AW-1:0] rd_addr;

	pipt_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.opcode(opcode),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sts(sts),
		.in_stall(in_stall),
		.rd_addr(rd_addr),
		.cmd(cmd)
	);

	pipt_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS(COORD_BITS),
		.AW(AW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.slot(slot),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.inside_res(inside_res),
		.on_edge(on_edge),
		.sts(sts)
	);

endmodule
